@@ rtl/masked_local_max_peak_finder_unit_defines.svh @@
// Assertion macros for the peak finder.
`ifndef MASKED_LOCAL_MAX_PEAK_FINDER_UNIT_DEFINES_SVH
`define MASKED_LOCAL_MAX_PEAK_FINDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MLMPF_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mlmpf check failed");
`define MLMPF_ASSERT_NR(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mlmpf reset check failed");
`else
`define MLMPF_ASSERT(name, prop)
`define MLMPF_ASSERT_NR(name, prop)
`endif

`endif

@@ rtl/mlmpf_pkg.sv @@
package mlmpf_pkg;

  localparam int PIX_W     = 16;
  localparam int MASK_W    = 8;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int GEOM_W    = 12;

  localparam logic signed [PIX_W-1:0] HEIGHT_THR_RST = 16'sd20;
  localparam logic [GEOM_W-1:0]       MIN_SEP_RST    = 12'd10;
  localparam logic [GEOM_W-1:0]       FRAME_DIM_RST  = 12'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_THRESHOLD = 2'd0,
    REG_MIN_SEPARATION   = 2'd1,
    REG_FRAME_COLS       = 2'd2,
    REG_FRAME_ROWS       = 2'd3
  } cfg_reg_t;

  // square-and-accumulate unit control
  typedef struct packed {
    logic load;   // acc = a*a
    logic accum;  // acc = acc + a*a
  } mac_ctl_t;

endpackage

@@ rtl/mlmpf_if.sv @@
interface mlmpf_pix_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mlmpf_pkg::PIX_W-1:0]     pixel;
  logic        [mlmpf_pkg::MASK_W-1:0]    mask;
  modport source (output valid, pixel, mask, input ready);
  modport sink   (input valid, pixel, mask, output ready);
endinterface

interface mlmpf_res_if;
  logic                                   valid;
  logic                                   ready;
  logic        [mlmpf_pkg::COL_W-1:0]     peak_col;
  logic        [mlmpf_pkg::ROW_W-1:0]     peak_row;
  logic signed [mlmpf_pkg::PIX_W-1:0]     peak_height;
  logic                                   found;
  logic                                   overflow;
  logic                                   last_peak;
  modport source (output valid, peak_col, peak_row, peak_height, found, overflow,
                  last_peak, input ready);
  modport sink   (input valid, peak_col, peak_row, peak_height, found, overflow,
                  last_peak, output ready);
endinterface

@@ rtl/mlmpf_mac.sv @@
module mlmpf_mac #(
  parameter int DW = 13
) (
  input  logic                      clk,
  input  mlmpf_pkg::mac_ctl_t       ctl,
  input  logic signed [DW-1:0]      a,
  output logic signed [2*DW:0]      acc
);

  logic signed [2*DW-1:0] sq;

  assign sq = a * a;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= (2*DW+1)'(sq);
    end else if (ctl.accum) begin
      acc <= acc + (2*DW+1)'(sq);
    end
  end

endmodule

@@ rtl/masked_local_max_peak_finder_unit.sv @@
// Masked 3x3 local-maximum peak finder with distance suppression.
// pix (sink): one pixel word (signed sample + mask byte) per handshake, raster
//   order. Each pixel goes through accept, line-memory read and window
//   evaluate before the next is accepted; the single line memory port sets this.
// res (source): peak records after the frame's last pixel; last_peak marks
//   the final one. A frame with no surviving peaks gives one record, found=0.
// Frame end: culling walks all pairs i<j of the n-entry table with one
//   shared square-accumulate unit, skipping any j already removed, then
//   a survivor scan, then the records, each held until the receiver takes it.
//   pix.ready is low through all of that.
// A stalled receiver holds the output register; nothing is dropped.
// Reset: config registers to defaults (threshold 20, separation 10,
//   512x512), counters, window and table fill clear. Line memory is not
//   cleared; the first two rows never read it for a candidate.
// cfg: write-only, index per register list, taken any cycle cfg_we is high;
//   write only while idle between frames.
`include "masked_local_max_peak_finder_unit_defines.svh"

module masked_local_max_peak_finder_unit #(
  parameter int MAX_COLS  = 2048,
  parameter int MAX_PEAKS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [mlmpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mlmpf_pkg::CFG_W-1:0]            cfg_data,
  mlmpf_pix_if.sink                              pix,
  mlmpf_res_if.source                            res
);

  localparam int PW   = mlmpf_pkg::PIX_W;
  localparam int RW   = mlmpf_pkg::ROW_W;
  localparam int GW   = mlmpf_pkg::GEOM_W;
  localparam int OCW  = mlmpf_pkg::COL_W;
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PIW  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int PCW  = $clog2(MAX_PEAKS + 1);
  localparam int DW   = ((CW > GW) ? CW : GW) + 1;
  localparam int AW   = 2*DW + 1;
  localparam int EW   = CW + RW + PW;
  localparam int LW   = 2*PW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_EVAL,
    S_DMIN, S_DMIN_WR,
    S_I_RD, S_I_LD, S_J_RD, S_DIFF, S_MC, S_MR, S_CMP,
    S_SCAN, S_E_RD, S_E_WAIT, S_E_OUT
  } state_t;

  state_t state;

  // configuration
  logic signed [PW-1:0] height_threshold;
  logic [GW-1:0]        min_separation, frame_cols, frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_threshold <= mlmpf_pkg::HEIGHT_THR_RST;
      min_separation   <= mlmpf_pkg::MIN_SEP_RST;
      frame_cols       <= mlmpf_pkg::FRAME_DIM_RST;
      frame_rows       <= mlmpf_pkg::FRAME_DIM_RST;
    end else if (cfg_we) begin
      case (mlmpf_pkg::cfg_reg_t'(cfg_index))
        mlmpf_pkg::REG_HEIGHT_THRESHOLD: height_threshold <= $signed(cfg_data[PW-1:0]);
        mlmpf_pkg::REG_MIN_SEPARATION:   min_separation   <= cfg_data[GW-1:0];
        mlmpf_pkg::REG_FRAME_COLS:       frame_cols       <= cfg_data[GW-1:0];
        mlmpf_pkg::REG_FRAME_ROWS:       frame_rows       <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: cols clamped to 1..MAX_COLS, rows 0 -> 1
  logic [CW:0]  cols_eff;
  logic [GW-1:0] rows_eff;

  always_comb begin
    if (32'(frame_cols) > 32'(MAX_COLS)) begin
      cols_eff = (CW+1)'(MAX_COLS);
    end else if (frame_cols == '0) begin
      cols_eff = (CW+1)'(1);
    end else begin
      cols_eff = (CW+1)'(frame_cols);
    end
    rows_eff = (frame_rows == '0) ? GW'(1) : frame_rows;
  end

  // counters and pixel latch
  logic [CW-1:0]        col_cnt;
  logic [RW-1:0]        row_cnt;
  logic signed [PW-1:0] px;
  logic                 mk;
  logic                 col_end, row_end;

  assign col_end = ({1'b0, col_cnt} + (CW+1)'(1)) >= cols_eff;
  assign row_end = ({1'b0, row_cnt} + (RW+1)'(1)) >= (RW+1)'(rows_eff);

  // line memory: {row r-2, row r-1, mask of row r-1}
  logic [LW-1:0] line_mem [MAX_COLS];
  logic [LW-1:0] line_rd;
  logic          line_we;

  assign line_we = (state == S_EVAL);

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[col_cnt] <= {line_rd[LW-1-PW -: PW], px, mk};
    end
    line_rd <= line_mem[col_cnt];
  end

  // 3x3 window columns; index 2 is newest
  logic signed [PW-1:0] w_top [3];
  logic signed [PW-1:0] w_mid [3];
  logic signed [PW-1:0] w_bot [3];
  logic                 w_m   [3];
  logic signed [PW-1:0] nc_top, nc_mid, v;
  logic                 nc_m, cand;

  assign nc_top = $signed(line_rd[LW-1 -: PW]);
  assign nc_mid = $signed(line_rd[PW:1]);
  assign nc_m   = line_rd[0];
  assign v      = w_mid[2];

  assign cand = (row_cnt >= RW'(2)) && (col_cnt >= CW'(2)) && w_m[2] &&
                (v >= height_threshold) &&
                (v >= w_top[2]) && (v >= w_bot[2]) &&
                (v >= w_top[1]) && (v >= w_mid[1]) && (v >= w_bot[1]) &&
                (v >= nc_top) && (v >= nc_mid) && (v >= px);

  // peak table
  logic [EW-1:0]        peak_mem [MAX_PEAKS];
  logic [EW-1:0]        peak_rd;
  logic [PCW-1:0]       peak_count;
  logic                 overflow_flag;
  logic                 peak_we;
  logic [PCW-1:0]       i_idx, j_idx;
  logic [PIW-1:0]       last_idx;
  logic [PIW-1:0]       rd_addr;

  assign peak_we = (state == S_EVAL) && cand && (32'(peak_count) < 32'(MAX_PEAKS));

  always_comb begin
    case (state)
      S_J_RD:  rd_addr = j_idx[PIW-1:0];
      default: rd_addr = i_idx[PIW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (peak_we) begin
      peak_mem[peak_count[PIW-1:0]] <= {col_cnt - CW'(1), row_cnt - RW'(1), v};
    end
    peak_rd <= peak_mem[rd_addr];
  end

  logic [CW-1:0]        rd_col;
  logic [RW-1:0]        rd_row;
  logic signed [PW-1:0] rd_h;

  assign rd_col = peak_rd[EW-1 -: CW];
  assign rd_row = peak_rd[PW +: RW];
  assign rd_h   = $signed(peak_rd[PW-1:0]);

  // culling datapath
  logic [CW-1:0]         ei_col;
  logic [RW-1:0]         ei_row;
  logic signed [PW-1:0]  ei_h, ej_h;
  logic signed [DW-1:0]  dc, dr, mac_a;
  logic signed [AW-1:0]  acc, dmin2;
  logic [MAX_PEAKS-1:0]  removed;
  logic                  any_left;
  mlmpf_pkg::mac_ctl_t   mac_ctl;

  always_comb begin
    mac_ctl = '0;
    mac_a   = dr;
    case (state)
      S_DMIN: begin
        mac_ctl.load = 1'b1;
        mac_a        = DW'(min_separation);
      end
      S_MC: begin
        mac_ctl.load = 1'b1;
        mac_a        = dc;
      end
      S_MR: begin
        mac_ctl.accum = 1'b1;
      end
      default: ;
    endcase
  end

  mlmpf_mac #(.DW(DW)) u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .acc (acc)
  );

  // output register
  logic                 o_valid, o_found, o_ovf, o_last;
  logic [OCW-1:0]       o_col;
  logic [RW-1:0]        o_row;
  logic signed [PW-1:0] o_h;

  assign pix.ready       = (state == S_IDLE);
  assign res.valid       = o_valid;
  assign res.peak_col    = o_col;
  assign res.peak_row    = o_row;
  assign res.peak_height = o_h;
  assign res.found       = o_found;
  assign res.overflow    = o_ovf;
  assign res.last_peak   = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      col_cnt       <= '0;
      row_cnt       <= '0;
      peak_count    <= '0;
      overflow_flag <= 1'b0;
      o_valid       <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        w_top[k] <= '0;
        w_mid[k] <= '0;
        w_bot[k] <= '0;
        w_m[k]   <= 1'b0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (pix.valid) begin
            px    <= pix.pixel;
            mk    <= (pix.mask != '0);
            state <= S_RD;
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          w_top[1] <= w_top[2];
          w_mid[1] <= w_mid[2];
          w_bot[1] <= w_bot[2];
          w_m[1]   <= w_m[2];
          w_top[2] <= nc_top;
          w_mid[2] <= nc_mid;
          w_bot[2] <= px;
          w_m[2]   <= nc_m;
          w_top[0] <= w_top[1];
          w_mid[0] <= w_mid[1];
          w_bot[0] <= w_bot[1];
          w_m[0]   <= w_m[1];
          if (peak_we) begin
            peak_count <= peak_count + PCW'(1);
          end else if (cand) begin
            overflow_flag <= 1'b1;
          end
          if (col_end) begin
            col_cnt <= '0;
            if (row_end) begin
              state <= S_DMIN;
            end else begin
              row_cnt <= row_cnt + RW'(1);
              state   <= S_IDLE;
            end
          end else begin
            col_cnt <= col_cnt + CW'(1);
            state   <= S_IDLE;
          end
        end
        S_DMIN: state <= S_DMIN_WR;
        S_DMIN_WR: begin
          dmin2    <= acc;
          removed  <= '0;
          any_left <= 1'b0;
          i_idx    <= '0;
          state    <= S_I_RD;
        end
        S_I_RD: begin
          if ((i_idx + PCW'(1)) >= peak_count) begin
            i_idx <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_I_LD;
          end
        end
        S_I_LD: begin
          ei_col <= rd_col;
          ei_row <= rd_row;
          ei_h   <= rd_h;
          j_idx  <= i_idx + PCW'(1);
          state  <= S_J_RD;
        end
        S_J_RD: begin
          if (j_idx >= peak_count) begin
            i_idx <= i_idx + PCW'(1);
            state <= S_I_RD;
          end else if (removed[j_idx[PIW-1:0]]) begin
            j_idx <= j_idx + PCW'(1);
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          dc    <= DW'(rd_col) - DW'(ei_col);
          dr    <= DW'(rd_row) - DW'(ei_row);
          ej_h  <= rd_h;
          state <= S_MC;
        end
        S_MC: state <= S_MR;
        S_MR: state <= S_CMP;
        S_CMP: begin
          if (acc < dmin2) begin
            if (ei_h > ej_h) begin
              removed[j_idx[PIW-1:0]] <= 1'b1;
            end else begin
              removed[i_idx[PIW-1:0]] <= 1'b1;
            end
          end
          j_idx <= j_idx + PCW'(1);
          state <= S_J_RD;
        end
        S_SCAN: begin
          if (i_idx >= peak_count) begin
            i_idx <= '0;
            if (any_left) begin
              state <= S_E_RD;
            end else begin
              // no survivors: single empty record
              o_col   <= '0;
              o_row   <= '0;
              o_h     <= '0;
              o_found <= 1'b0;
              o_ovf   <= overflow_flag;
              o_last  <= 1'b1;
              o_valid <= 1'b1;
              state   <= S_E_OUT;
            end
          end else begin
            if (!removed[i_idx[PIW-1:0]]) begin
              last_idx <= i_idx[PIW-1:0];
              any_left <= 1'b1;
            end
            i_idx <= i_idx + PCW'(1);
          end
        end
        S_E_RD: begin
          if (removed[i_idx[PIW-1:0]]) begin
            i_idx <= i_idx + PCW'(1);
          end else begin
            state <= S_E_WAIT;
          end
        end
        S_E_WAIT: begin
          o_col   <= OCW'(rd_col);
          o_row   <= rd_row;
          o_h     <= rd_h;
          o_found <= 1'b1;
          o_ovf   <= overflow_flag;
          o_last  <= (i_idx[PIW-1:0] == last_idx);
          o_valid <= 1'b1;
          state   <= S_E_OUT;
        end
        S_E_OUT: begin
          if (res.ready) begin
            o_valid <= 1'b0;
            if (o_last) begin
              col_cnt       <= '0;
              row_cnt       <= '0;
              peak_count    <= '0;
              overflow_flag <= 1'b0;
              state         <= S_IDLE;
            end else begin
              i_idx <= i_idx + PCW'(1);
              state <= S_E_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MLMPF_ASSERT(a_no_accept_while_out, !(pix.ready && res.valid))
  `MLMPF_ASSERT(a_count_bound, 32'(peak_count) <= 32'(MAX_PEAKS))
  `MLMPF_ASSERT(a_ovf_full, overflow_flag |-> (32'(peak_count) == 32'(MAX_PEAKS)))
  `MLMPF_ASSERT(a_frame_clear, (res.valid && res.ready && res.last_peak) |=> ((peak_count == '0) && !overflow_flag && pix.ready))
  `MLMPF_ASSERT_NR(a_reset_quiet, rst |=> !res.valid)

endmodule

@@ verif/tb_masked_local_max_peak_finder_unit.sv @@
`timescale 1ns / 100ps

module tb_masked_local_max_peak_finder_unit;

  localparam int LINE_LEN   = 2048;  // matches the block's MAX_COLS
  localparam int TABLE_LEN  = 64;    // matches the block's MAX_PEAKS
  localparam int STALL_MAX  = 100000; // cycles with no word moved before giving up
  localparam int LONG_HOLD  = 400;   // receiver hold-off used once
  localparam int DRAIN_WAIT = 12;    // settle time after the last record

  typedef struct {
    logic signed [mlmpf_pkg::PIX_W-1:0]  pixel;
    logic        [mlmpf_pkg::MASK_W-1:0] mask;
  } pix_word_t;

  typedef struct {
    logic        [mlmpf_pkg::COL_W-1:0] col;
    logic        [mlmpf_pkg::ROW_W-1:0] row;
    logic signed [mlmpf_pkg::PIX_W-1:0] height;
    logic                               found;
    logic                               overflow;
    logic                               last;
  } peak_rec_t;

  typedef struct {
    int   top;
    int   mid;
    int   bot;
    logic mmask;
  } win_col_t;

  // frame contents
  typedef enum int {
    FK_RANDOM,   // small-range random
    FK_FLAT,     // flat plateau
    FK_EXTREME,  // extremes
    FK_FULL      // full random
  } frame_kind_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [mlmpf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mlmpf_pkg::CFG_W-1:0]     cfg_data;

  mlmpf_pix_if pix ();
  mlmpf_res_if res ();

  masked_local_max_peak_finder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix      (pix.sink),
    .res      (res.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor: mirrors the block's line stores, 3x3 window, candidate table
  // and end-of-frame culling. Updated on each accepted pixel word.
  // ---------------------------------------------------------------------------
  int        thr_q;           // height threshold, sign-extended
  int        sep_q;           // minimum separation
  int        cols_q, rows_q;  // raw geometry as written
  int        line_top  [LINE_LEN];
  int        line_mid  [LINE_LEN];
  logic      line_mask [LINE_LEN];
  win_col_t  win [3];
  int        col_pos, row_pos;
  int        tbl_col [TABLE_LEN];
  int        tbl_row [TABLE_LEN];
  int        tbl_h   [TABLE_LEN];
  logic      tbl_gone[TABLE_LEN];
  int        tbl_n;
  logic      tbl_ovf;

  peak_rec_t pending_peaks[$];  // records the block still owes
  pix_word_t pixel_feed[$];     // pixel words waiting for the driver

  int  errors;
  int  idle_cycles;
  logic quiet;      // no random idling in the last part of the run
  logic hold_req;   // asks the monitor for one long hold-off
  logic src_pause;

  function automatic int eff_cols(int raw);
    if (raw > LINE_LEN) return LINE_LEN;
    if (raw == 0) return 1;
    return raw;
  endfunction

  function automatic int eff_rows(int raw);
    return (raw == 0) ? 1 : raw;
  endfunction

  function automatic void add_word(pix_word_t w);
    pixel_feed.insert(pixel_feed.size(), w);
  endfunction

  function automatic void push_peak(int c, int r, int h, logic f, logic l);
    peak_rec_t p;
    p.col      = c[mlmpf_pkg::COL_W-1:0];
    p.row      = r[mlmpf_pkg::ROW_W-1:0];
    p.height   = h[mlmpf_pkg::PIX_W-1:0];
    p.found    = f;
    p.overflow = tbl_ovf;
    p.last     = l;
    pending_peaks.insert(pending_peaks.size(), p);
  endfunction

  // Pairwise distance suppression, then survivors in table order.
  function automatic void cull_and_emit();
    longint d2min, dc, dr;
    int     last_i;
    logic   any;
    d2min = longint'(sep_q) * longint'(sep_q);
    last_i = 0;
    any = 1'b0;
    for (int i = 0; i < tbl_n; i++) tbl_gone[i] = 1'b0;
    for (int i = 0; i + 1 < tbl_n; i++) begin
      for (int j = i + 1; j < tbl_n; j++) begin
        if (tbl_gone[j]) continue;
        dc = tbl_col[j] - tbl_col[i];
        dr = tbl_row[j] - tbl_row[i];
        if (dc * dc + dr * dr < d2min) begin
          // a removed i keeps suppressing later entries
          if (tbl_h[i] > tbl_h[j]) tbl_gone[j] = 1'b1;
          else tbl_gone[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < tbl_n; i++)
      if (!tbl_gone[i]) begin
        last_i = i;
        any = 1'b1;
      end
    if (!any) begin
      push_peak(0, 0, 0, 1'b0, 1'b1);  // nothing survived: one not-found record
    end else begin
      for (int i = 0; i < tbl_n; i++)
        if (!tbl_gone[i]) push_peak(tbl_col[i], tbl_row[i], tbl_h[i], 1'b1, i == last_i);
    end
    col_pos = 0;
    row_pos = 0;
    tbl_n   = 0;
    tbl_ovf = 1'b0;
  endfunction

  function automatic void pixel_pred(pix_word_t w);
    int       cols, rows, ci, v;
    win_col_t nc;
    logic     is_max;
    cols = eff_cols(cols_q);
    rows = eff_rows(rows_q);
    ci = (col_pos < LINE_LEN) ? col_pos : LINE_LEN - 1;
    nc.top   = line_top[ci];
    nc.mid   = line_mid[ci];
    nc.bot   = int'(w.pixel);
    nc.mmask = line_mask[ci];
    line_top[ci]  = nc.mid;
    line_mid[ci]  = int'(w.pixel);
    line_mask[ci] = (w.mask != '0);
    win[0] = win[1];
    win[1] = win[2];
    win[2] = nc;
    if (row_pos >= 2 && col_pos >= 2 && win[1].mmask) begin
      v = win[1].mid;
      is_max = v >= thr_q && v >= win[1].top && v >= win[1].bot &&
               v >= win[0].top && v >= win[0].mid && v >= win[0].bot &&
               v >= win[2].top && v >= win[2].mid && v >= win[2].bot;
      if (is_max) begin
        if (tbl_n < TABLE_LEN) begin
          tbl_col[tbl_n] = col_pos - 1;
          tbl_row[tbl_n] = row_pos - 1;
          tbl_h[tbl_n]   = v;
          tbl_n++;
        end else begin
          tbl_ovf = 1'b1;
        end
      end
    end
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      if (row_pos + 1 >= rows) cull_and_emit();
      else row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: moves pixel words from the feed queue onto pix, with random gaps.
  // ---------------------------------------------------------------------------
  int src_gap;

  always @(posedge clk) begin
    pix_word_t w;
    if (rst) begin
      pix.valid <= 1'b0;
      pix.pixel <= '0;
      pix.mask  <= '0;
      src_gap = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        w.pixel = pix.pixel;
        w.mask  = pix.mask;
        pixel_pred(w);
      end
      if (!pix.valid || pix.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          pix.valid <= 1'b0;
        end else if (pixel_feed.size() > 0 && !src_pause) begin
          w = pixel_feed.pop_front();
          pix.valid <= 1'b1;
          pix.pixel <= w.pixel;
          pix.mask  <= w.mask;
          if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 4);
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted record against the oldest expected one and
  // drives res.ready with random stalls plus one long hold-off.
  // ---------------------------------------------------------------------------
  int   snk_gap;
  int   hold_cnt;
  logic hold_done;

  always @(posedge clk) begin
    peak_rec_t e;
    if (rst) begin
      res.ready <= 1'b0;
      snk_gap = 0;
      hold_cnt = 0;
      hold_done = 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_peaks.size() == 0) begin
          report("unexpected record", {res.peak_row, res.peak_col}, 0);
        end else begin
          e = pending_peaks.pop_front();
          if (res.found !== e.found) report("found", res.found, e.found);
          if (res.overflow !== e.overflow) report("overflow", res.overflow, e.overflow);
          if (res.last_peak !== e.last) report("last_peak", res.last_peak, e.last);
          if (res.peak_col !== e.col) report("peak_col", res.peak_col, e.col);
          if (res.peak_row !== e.row) report("peak_row", res.peak_row, e.row);
          if (res.peak_height !== e.height) report("peak_height", res.peak_height, e.height);
        end
      end
      if (hold_req && !hold_done) begin
        hold_cnt = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) snk_gap = $urandom_range(1, 4);
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("tb_masked_local_max_peak_finder_unit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic cfg_write(mlmpf_pkg::cfg_reg_t idx, logic [mlmpf_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      mlmpf_pkg::REG_HEIGHT_THRESHOLD: thr_q  = int'($signed(data));
      mlmpf_pkg::REG_MIN_SEPARATION:   sep_q  = int'(data[mlmpf_pkg::GEOM_W-1:0]);
      mlmpf_pkg::REG_FRAME_COLS:       cols_q = int'(data[mlmpf_pkg::GEOM_W-1:0]);
      mlmpf_pkg::REG_FRAME_ROWS:       rows_q = int'(data[mlmpf_pkg::GEOM_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every word is sent and every record has come back.
  task automatic drain();
    while (pixel_feed.size() > 0 || pix.valid || pending_peaks.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_all(int thr, int sep, int cols, int rows);
    cfg_write(mlmpf_pkg::REG_HEIGHT_THRESHOLD, thr[mlmpf_pkg::CFG_W-1:0]);
    cfg_write(mlmpf_pkg::REG_MIN_SEPARATION, sep[mlmpf_pkg::CFG_W-1:0]);
    cfg_write(mlmpf_pkg::REG_FRAME_COLS, cols[mlmpf_pkg::CFG_W-1:0]);
    cfg_write(mlmpf_pkg::REG_FRAME_ROWS, rows[mlmpf_pkg::CFG_W-1:0]);
  endtask

  task automatic queue_frame(frame_kind_t kind);
    pix_word_t w;
    int n;
    n = eff_cols(cols_q) * eff_rows(rows_q);
    for (int k = 0; k < n; k++) begin
      case (kind)
        FK_FLAT: begin
          w.pixel = '0;
          w.mask  = 8'hff;
        end
        FK_EXTREME: begin
          case ($urandom_range(0, 3))
            0: w.pixel = 16'sh8000;
            1: w.pixel = 16'sh7fff;
            2: w.pixel = 16'sh0000;
            default: w.pixel = 16'shffff;
          endcase
          case ($urandom_range(0, 3))
            0: w.mask = 8'h00;
            1: w.mask = 8'h01;
            2: w.mask = 8'h80;
            default: w.mask = 8'hff;
          endcase
        end
        FK_FULL: begin
          w.pixel = 16'($urandom);
          w.mask  = 8'($urandom);
        end
        default: begin
          // small range gives ties, plateaus and peaks near the threshold
          w.pixel = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
                    16'(int'($urandom_range(0, 60)) - 30);
          w.mask  = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        end
      endcase
      add_word(w);
    end
  endtask

  initial begin
    int nf;
    int fl;
    errors      = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    src_pause   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = mlmpf_pkg::REG_HEIGHT_THRESHOLD;
    cfg_data    = '0;
    // predictor reset state
    thr_q  = int'(mlmpf_pkg::HEIGHT_THR_RST);
    sep_q  = int'(mlmpf_pkg::MIN_SEP_RST);
    cols_q = int'(mlmpf_pkg::FRAME_DIM_RST);
    rows_q = int'(mlmpf_pkg::FRAME_DIM_RST);
    foreach (line_top[i]) begin
      line_top[i]  = 0;
      line_mid[i]  = 0;
      line_mask[i] = 1'b0;
    end
    foreach (win[i]) win[i] = '{0, 0, 0, 1'b0};
    col_pos = 0;
    row_pos = 0;
    tbl_n   = 0;
    tbl_ovf = 1'b0;

    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: flat zero frame under default threshold -> not-found record
    cfg_write(mlmpf_pkg::REG_FRAME_COLS, 16'd3);
    cfg_write(mlmpf_pkg::REG_FRAME_ROWS, 16'd3);
    add_word('{16'sd0, 8'h00});
    repeat (8) add_word('{16'sd0, 8'hff});
    drain();
    // extreme samples and mask bytes, any value passes
    set_all(-32768, 4095, 4, 4);
    queue_frame(FK_EXTREME);
    drain();
    // plateau wider than the table: overflow, no suppression
    set_all(-32768, 0, 12, 9);
    queue_frame(FK_FLAT);
    drain();
    // zero geometry means one pixel per frame; then 2x2, too small for peaks
    set_all(32767, 1, 0, 0);
    queue_frame(FK_FULL);
    drain();
    set_all(-5, 2, 2, 2);
    queue_frame(FK_FULL);
    drain();

    // random phases, one or two frames each under one setting
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) quiet = 1'b1;
      set_all(int'($urandom_range(0, 50)) - 25, int'($urandom_range(0, 8)),
              int'($urandom_range(3, 5)), int'($urandom_range(3, 4)));
      nf = (ph == 0 || ph == 2) ? 2 : int'($urandom_range(1, 2));
      // first random phase: receiver holds off while frames keep coming
      if (ph == 0) hold_req = 1'b1;
      for (int f = 0; f < nf; f++) queue_frame((ph % 4 == 3) ? FK_FULL : FK_RANDOM);
      if (ph == 2) begin
        // after the first frame the sender waits for every record so far
        fl = eff_cols(cols_q) * eff_rows(rows_q);
        while (pixel_feed.size() > (nf - 1) * fl) @(posedge clk);
        src_pause = 1'b1;
        do @(posedge clk); while (pix.valid || pending_peaks.size() > 0);
        src_pause = 1'b0;
      end
      drain();
    end

    set_all(-10, 5, 5, 5);
    queue_frame(FK_RANDOM);
    drain();

    if (errors == 0) begin
      $display("tb_masked_local_max_peak_finder_unit: PASS");
    end else begin
      $display("tb_masked_local_max_peak_finder_unit: FAIL");
    end
    $finish;
  end

endmodule
